FILE: rtl/rcpws_pkg.sv
`default_nettype none

package rcpws_pkg;

    localparam int TICK_W    = 8;
    localparam int US_W      = 13;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;

    localparam logic [US_W-1:0]  RST_MIN_WIDTH   = 13'd800;
    localparam logic [US_W-1:0]  RST_MAX_WIDTH   = 13'd2200;
    localparam logic [US_W-1:0]  RST_SPLIT_WIDTH = 13'd1500;
    localparam logic [CNT_W-1:0] RST_CEILING     = 5'd30;
    localparam logic [CNT_W-1:0] RST_THRESHOLD   = 5'd15;

    // ticks * 1000 / 56 = ticks * 125 / 7, the /7 done by reciprocal multiply
    localparam int SCALED_W    = 15;
    localparam int PROD_W      = 31;
    localparam int RECIP_SHIFT = 18;
    localparam logic [SCALED_W-1:0] TICK_MUL = 15'd125;
    localparam logic [PROD_W-1:0]   RECIP_M  = 31'd37450;

    typedef struct packed {
        logic [US_W-1:0]  min_width_us;
        logic [US_W-1:0]  max_width_us;
        logic [US_W-1:0]  split_width_us;
        logic [CNT_W-1:0] count_ceiling;
        logic [CNT_W-1:0] on_threshold;
    } cfg_t;

    typedef struct packed {
        logic [TICK_W-1:0] edge_capture;
        logic [CNT_W-1:0]  integrator;
        logic              switch_level;
    } state_t;

    typedef struct packed {
        logic              pin_level;
        logic [TICK_W-1:0] timer_count;
    } item_t;

    typedef struct packed {
        logic              switch_out;
        logic [US_W-1:0]   pulse_width_us;
        logic              pulse_valid;
        logic [CNT_W-1:0]  hold_count;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/rcpws_cfg.sv
`default_nettype none

module rcpws_cfg
    import rcpws_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_DAT_W-1:0] wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_MIN_WIDTH:   cfg_next.min_width_us   = wr_data[US_W-1:0];
                CFG_MAX_WIDTH:   cfg_next.max_width_us   = wr_data[US_W-1:0];
                CFG_SPLIT_WIDTH: cfg_next.split_width_us = wr_data[US_W-1:0];
                CFG_CEILING:     cfg_next.count_ceiling  = wr_data[CNT_W-1:0];
                CFG_THRESHOLD:   cfg_next.on_threshold   = wr_data[CNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_width_us   <= RST_MIN_WIDTH;
            cfg_reg.max_width_us   <= RST_MAX_WIDTH;
            cfg_reg.split_width_us <= RST_SPLIT_WIDTH;
            cfg_reg.count_ceiling  <= RST_CEILING;
            cfg_reg.on_threshold   <= RST_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/rcpws_calc.sv
`default_nettype none

module rcpws_calc
    import rcpws_pkg::*;
(
    input  wire item_t  item,
    input  wire state_t state,
    input  wire cfg_t   cfg,
    output state_t  state_next,
    output result_t result
);

    logic [TICK_W-1:0]   ticks;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;
    logic [US_W-1:0]     width_us;
    logic                in_window;
    logic                step_up;
    logic [CNT_W-1:0]    cnt_stepped;
    logic                do_count;

    assign ticks    = item.timer_count - state.edge_capture;
    assign scaled   = SCALED_W'(ticks) * TICK_MUL;
    assign prod     = PROD_W'(scaled) * RECIP_M;
    assign width_us = prod[RECIP_SHIFT +: US_W];

    assign in_window = (width_us > cfg.min_width_us) && (width_us < cfg.max_width_us);
    assign step_up   = width_us > cfg.split_width_us;
    assign do_count  = !item.pin_level && in_window;

    // saturating step toward ceiling or zero
    always_comb begin
        if (step_up) begin
            cnt_stepped = (state.integrator < cfg.count_ceiling) ?
                          state.integrator + CNT_W'(1) : cfg.count_ceiling;
        end else begin
            cnt_stepped = (state.integrator != '0) ?
                          state.integrator - CNT_W'(1) : '0;
        end
    end

    always_comb begin
        state_next = state;
        if (item.pin_level) begin
            state_next.edge_capture = item.timer_count;
        end else begin
            // a falling edge leaves the width in ticks as the new capture
            state_next.edge_capture = ticks;
            if (in_window) begin
                state_next.integrator   = cnt_stepped;
                state_next.switch_level = cnt_stepped > cfg.on_threshold;
            end
        end
    end

    assign result.switch_out     = state_next.switch_level;
    assign result.pulse_width_us = item.pin_level ? '0 : width_us;
    assign result.pulse_valid    = do_count;
    assign result.hold_count     = state_next.integrator;

endmodule

`default_nettype wire

FILE: rtl/rc_pulse_width_switch.sv
// channel | handshake            | payload
// --------+----------------------+----------------------------------------------
// s_      | s_valid / s_ready    | s_pin_level, s_timer_count
// m_      | m_valid / m_ready    | m_switch_out, m_pulse_width_us, m_pulse_valid,
//         |                      | m_hold_count
// cfg_    | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// one beat per cycle sustained while m_ready is high; a result beat passes the input register
// and then, in one pass of subtract, constant scale and compares, enters the result register,
// which is also where edge capture and counter update.
// reset clears both stage valids, the state and the configuration registers to defaults.
// a stalled m_ channel holds its beat; s_ready drops only when both stages are full.
// cfg_ready is always high.
`default_nettype none

module rc_pulse_width_switch
    import rcpws_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_pin_level,
    input  wire logic [TICK_W-1:0]    s_timer_count,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_switch_out,
    output logic [US_W-1:0]           m_pulse_width_us,
    output logic                      m_pulse_valid,
    output logic [CNT_W-1:0]          m_hold_count,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_vld_reg;
    logic    out_vld_reg;
    result_t out_res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result;
    logic    advance;
    logic    s_take;

    assign cfg_ready = 1'b1;

    rcpws_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    rcpws_calc u_calc (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result)
    );

    // result register can take a new beat
    assign advance = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
            if (advance && in_vld_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.pin_level   <= s_pin_level;
            in_item_reg.timer_count <= s_timer_count;
        end
        if (advance && in_vld_reg) begin
            out_res_reg <= result;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_switch_out     = out_res_reg.switch_out;
    assign m_pulse_width_us = out_res_reg.pulse_width_us;
    assign m_pulse_valid    = out_res_reg.pulse_valid;
    assign m_hold_count     = out_res_reg.hold_count;

endmodule

`default_nettype wire

FILE: rtl/rcpws_checker.sv
`default_nettype none

module rcpws_checker
    import rcpws_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic             m_switch_out,
    input wire logic [US_W-1:0]  m_pulse_width_us,
    input wire logic             m_pulse_valid,
    input wire logic [CNT_W-1:0] m_hold_count
);

    localparam logic [US_W-1:0] MAX_US = 13'd4553;

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("pipeline not empty after reset");

    // a stalled result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_switch_out)
            && $stable(m_pulse_width_us) && $stable(m_pulse_valid)
            && $stable(m_hold_count)))
        else $error("result beat changed while stalled");

    // scaled width never exceeds a full timer wrap
    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pulse_width_us <= MAX_US))
        else $error("pulse width out of range");

    // a counted pulse lies strictly above the window floor, so it is never zero
    a_valid_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pulse_valid) |-> (m_pulse_width_us != '0))
        else $error("counted pulse with zero width");

endmodule

bind rc_pulse_width_switch rcpws_checker u_rcpws_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_switch_out     (m_switch_out),
    .m_pulse_width_us (m_pulse_width_us),
    .m_pulse_valid    (m_pulse_valid),
    .m_hold_count     (m_hold_count)
);

`default_nettype wire
